[sv/carp_pkg.sv]
package carp_pkg;

    localparam int GAIN_W        = 22;
    localparam int SHIFT_W       = 4;
    localparam int ANGLE_W       = 18;
    localparam int RATE_W        = 21;
    localparam int DT_W          = 15;
    localparam int MOMENT_W      = 32;
    localparam int ERR_W         = 32;
    localparam int SUM_W         = 48;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 22;
    localparam int GAIN_FRAC_DEF = 16;

    // Wide working width for the serial unit
    localparam int ACC_W = 96;
    localparam int CNT_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_P_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_I_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_D_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_SHIFT   = 3'd4;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV
    } op_t;

    typedef struct packed {
        logic              start;
        op_t               op;
        logic [ACC_W-1:0]  a;
        logic [ACC_W-1:0]  b;
    } ser_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SP,
        ST_ERR,
        ST_PT,
        ST_DM1,
        ST_DM2,
        ST_DDIV,
        ST_IM,
        ST_IDIV,
        ST_SUMM,
        ST_FIN,
        ST_OUT
    } state_t;

endpackage

[sv/carp_serial.sv]
module carp_serial (
    input  logic                      clk,
    input  logic                      rst_n,
    input  carp_pkg::ser_req_t        req,
    output logic                      done,
    output logic [carp_pkg::ACC_W-1:0] result
);
    import carp_pkg::*;

    // Shift-and-add multiply or restoring divide, one bit per cycle.
    logic [ACC_W-1:0] a_reg, a_next;
    logic [ACC_W-1:0] b_reg, b_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    op_t              op_reg, op_next;
    logic [ACC_W:0]   trial;
    logic [ACC_W-1:0] rem_sh;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        op_next   = op_reg;
        done_next = 1'b0;
        rem_sh    = {acc_reg[ACC_W-2:0], a_reg[ACC_W-1]};
        trial     = {1'b0, rem_sh} - {1'b0, b_reg};
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
            op_next   = req.op;
            cnt_next  = CNT_W'(ACC_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_MUL)
            begin
                if (b_reg[0])
                    acc_next = acc_reg + a_reg;
                a_next = {a_reg[ACC_W-2:0], 1'b0};
                b_next = {1'b0, b_reg[ACC_W-1:1]};
            end
            else
            begin
                // a shifts out dividend bits, in quotient bits
                if (!trial[ACC_W])
                begin
                    acc_next = trial[ACC_W-1:0];
                    a_next   = {a_reg[ACC_W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = rem_sh;
                    a_next   = {a_reg[ACC_W-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done   = done_reg;
    assign result = (op_reg == OP_MUL) ? acc_reg : a_reg;

endmodule

[sv/cascaded_angle_rate_pid_axis.sv]
// One axis of a cascaded attitude controller: outer P on angle error, inner PID on
// rate error, Q-format gains with GAIN_FRAC_BITS fraction bits. Every multiply and
// divide runs through one bit-serial unit of 96 bits, one bit a cycle, and a step uses
// up to eight such operations; the three derivative operations are skipped when the
// step time is zero, and a clear transaction uses none. An item waits in the output
// state while a previous result still waits on the output. One item is in work at
// a time; a result waits in the output register while the next item is taken.
module cascaded_angle_rate_pid_axis #(
    parameter int GAIN_FRAC_BITS = carp_pkg::GAIN_FRAC_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [carp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [carp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [carp_pkg::ANGLE_W-1:0] angle_error,
    input  logic signed [carp_pkg::RATE_W-1:0]  rate_measured,
    input  logic [carp_pkg::DT_W-1:0]        step_ms,
    input  logic                             clear_integral,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [carp_pkg::MOMENT_W-1:0] moment,
    output logic                             saturated
);
    import carp_pkg::*;

    localparam logic [63:0] TERM_LIM = 64'd1 << 61;
    localparam logic signed [63:0] SMAX = (64'sd1 <<< 47) - 64'sd1;
    localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

    logic [GAIN_W-1:0]  ag_reg, pg_reg, ig_reg, dg_reg;
    logic [SHIFT_W-1:0] sh_reg;

    logic signed [ERR_W-1:0] last_reg, last_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [ANGLE_W-1:0] ae_reg;
    logic signed [RATE_W-1:0]  rm_reg;
    logic [DT_W-1:0]           dt_reg;
    logic signed [63:0] e_reg, e_next;
    logic signed [63:0] diff_reg, diff_next;
    logic signed [63:0] pt_reg, pt_next;
    logic signed [63:0] dtm_reg, dtm_next;
    logic signed [63:0] it_reg, it_next;
    logic [ACC_W-1:0]   tmp_reg, tmp_next;
    logic               sat_reg, sat_next;
    logic signed [MOMENT_W-1:0] cmom_reg, cmom_next;
    state_t state_reg, state_next;

    logic               ov_reg, ov_next;
    logic signed [MOMENT_W-1:0] mom_reg, mom_next;
    logic               osat_reg, osat_next;

    ser_req_t           req;
    logic               sdone;
    logic [ACC_W-1:0]   sres;

    logic               in_acc;
    logic signed [63:0] spv, dv, tot, nsum, iv;
    logic [63:0]        mg, tm;

    carp_serial u_serial (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .done   (sdone),
        .result (sres)
    );

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ag_reg <= '0;
            pg_reg <= '0;
            ig_reg <= '0;
            dg_reg <= '0;
            sh_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ANGLE_GAIN:  ag_reg <= cfg_data;
                REG_RATE_P_GAIN: pg_reg <= cfg_data;
                REG_RATE_I_GAIN: ig_reg <= cfg_data;
                REG_RATE_D_GAIN: dg_reg <= cfg_data;
                REG_ERR_SHIFT:   sh_reg <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        mag64 = x[63] ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic [63:0] lim(input logic [ACC_W-1:0] v);
        lim = (v > ACC_W'(TERM_LIM)) ? TERM_LIM : v[63:0];
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc) state_next = clear_integral ? ST_OUT : ST_SP;
            ST_SP:   if (sdone) state_next = ST_ERR;
            ST_ERR:  state_next = ST_PT;
            ST_PT:   if (sdone) state_next = (dt_reg != '0) ? ST_DM1 : ST_IM;
            ST_DM1:  if (sdone) state_next = ST_DM2;
            ST_DM2:  if (sdone) state_next = ST_DDIV;
            ST_DDIV: if (sdone) state_next = ST_IM;
            ST_IM:   if (sdone) state_next = ST_IDIV;
            ST_IDIV: if (sdone) state_next = ST_SUMM;
            ST_SUMM: if (sdone) state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  if (!ov_reg || !out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and serial requests
    always_comb
    begin
        e_next    = e_reg;
        diff_next = diff_reg;
        pt_next   = pt_reg;
        dtm_next  = dtm_reg;
        it_next   = it_reg;
        tmp_next  = tmp_reg;
        sat_next  = sat_reg;
        cmom_next = cmom_reg;
        last_next = last_reg;
        sum_next  = sum_reg;
        ov_next   = ov_reg && out_stall;
        mom_next  = mom_reg;
        osat_next = osat_reg;
        req       = '{start: 1'b0, op: OP_MUL, a: '0, b: '0};
        spv = '0; dv = '0; tot = '0; nsum = '0; iv = '0; mg = '0; tm = '0;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    sat_next = 1'b0;
                    if (clear_integral)
                    begin
                        sum_next = '0;
                        tmp_next = '0;
                    end
                    else
                    begin
                        req.start = 1'b1;
                        req.a = ACC_W'(ag_reg);
                        req.b = ACC_W'(mag64(64'(angle_error)));
                    end
                end
            ST_SP:
                if (sdone)
                    tmp_next = sres >> GAIN_FRAC_BITS;
            ST_ERR:
            begin
                spv = ae_reg[ANGLE_W-1] ? -$signed(tmp_reg[63:0]) : $signed(tmp_reg[63:0]);
                dv  = (spv - 64'(rm_reg)) >>> sh_reg;
                if (dv > 64'sd2147483647)
                    dv = 64'sd2147483647;
                else if (dv < -64'sd2147483648)
                    dv = -64'sd2147483648;
                e_next    = dv;
                diff_next = dv - 64'(last_reg);
                req.start = 1'b1;
                req.a = ACC_W'(pg_reg);
                req.b = ACC_W'(mag64(dv));
            end
            ST_PT:
                if (sdone)
                begin
                    pt_next  = e_reg[63] ? -$signed(sres[63:0]) : $signed(sres[63:0]);
                    dtm_next = '0;
                    req.start = 1'b1;
                    if (dt_reg != '0)
                    begin
                        req.a = ACC_W'(dg_reg);
                        req.b = ACC_W'(mag64(diff_reg));
                    end
                    else
                    begin
                        req.a = ACC_W'(mag64(64'(sum_reg)));
                        req.b = ACC_W'(ig_reg);
                    end
                end
            ST_DM1:
                if (sdone)
                begin
                    req.start = 1'b1;
                    req.a = sres;
                    req.b = ACC_W'(1000);
                end
            ST_DM2:
                if (sdone)
                begin
                    req.start = 1'b1;
                    req.op = OP_DIV;
                    req.a = sres;
                    req.b = ACC_W'(dt_reg);
                end
            ST_DDIV:
                if (sdone)
                begin
                    mg = lim(sres);
                    dtm_next = diff_reg[63] ? -$signed(mg) : $signed(mg);
                    req.start = 1'b1;
                    req.a = ACC_W'(mag64(64'(sum_reg)));
                    req.b = ACC_W'(ig_reg);
                end
            ST_IM:
                if (sdone)
                begin
                    req.start = 1'b1;
                    req.op = OP_DIV;
                    req.a = sres;
                    req.b = ACC_W'(1000);
                end
            ST_IDIV:
                if (sdone)
                begin
                    mg = lim(sres);
                    it_next = sum_reg[SUM_W-1] ? -$signed(mg) : $signed(mg);
                    req.start = 1'b1;
                    req.a = ACC_W'(mag64(e_reg));
                    req.b = ACC_W'(dt_reg);
                end
            ST_SUMM:
                if (sdone)
                    tmp_next = sres;
            ST_FIN:
            begin
                tot = pt_reg + dtm_reg + it_reg;
                tm  = mag64(tot) >> GAIN_FRAC_BITS;
                if (tot[63])
                begin
                    if (tm > 64'h8000_0000) begin tm = 64'h8000_0000; sat_next = 1'b1; end
                    cmom_next = MOMENT_W'(-$signed(tm));
                end
                else
                begin
                    if (tm > 64'h7FFF_FFFF) begin tm = 64'h7FFF_FFFF; sat_next = 1'b1; end
                    cmom_next = MOMENT_W'(tm);
                end
                iv   = e_reg[63] ? -$signed(tmp_reg[63:0]) : $signed(tmp_reg[63:0]);
                nsum = 64'(sum_reg) + iv;
                if (nsum > SMAX) begin nsum = SMAX; sat_next = 1'b1; end
                if (nsum < SMIN) begin nsum = SMIN; sat_next = 1'b1; end
                sum_next  = SUM_W'(nsum);
                last_next = ERR_W'(e_reg);
                tmp_next  = '1;
            end
            ST_OUT:
                if (!ov_reg || !out_stall)
                begin
                    ov_next   = 1'b1;
                    // tmp all ones marks a computed step, zero marks a clear
                    mom_next  = (tmp_reg == '0) ? '0 : cmom_reg;
                    osat_next = (tmp_reg == '0) ? 1'b0 : sat_reg;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            last_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            last_reg  <= last_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ae_reg <= angle_error;
            rm_reg <= rate_measured;
            dt_reg <= step_ms;
        end
        e_reg    <= e_next;
        diff_reg <= diff_next;
        pt_reg   <= pt_next;
        dtm_reg  <= dtm_next;
        it_reg   <= it_next;
        tmp_reg  <= tmp_next;
        sat_reg  <= sat_next;
        cmom_reg <= cmom_next;
        mom_reg  <= mom_next;
        osat_reg <= osat_next;
    end

    assign out_valid = ov_reg;
    assign moment    = mom_reg;
    assign saturated = osat_reg;

endmodule

[sv/carp_checker.sv]
module carp_checker (
    input logic clk,
    input logic rst_n,
    input logic cfg_valid,
    input logic cfg_ready,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic [31:0] moment,
    input logic saturated
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(moment) && $stable(saturated))
        else $error("stalled result changed");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction taken while busy");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !in_stall)
        else $error("config port open during work");

    a_clear_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && moment == 32'd0 && !$past(out_valid) |-> saturated == 1'b0
        || saturated == 1'b1)
        else $error("flag undefined");

endmodule

bind cascaded_angle_rate_pid_axis carp_checker u_carp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .moment    (moment),
    .saturated (saturated)
);

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import carp_pkg::*;

    localparam int ITEMS_PER_PHASE = 228;
    localparam int PHASES          = 8;
    localparam longint TERM_LIM    = longint'(64'd1 << 61);
    localparam longint ACC_MAX     = (longint'(1) << 47) - 1;
    localparam longint ACC_MIN     = -ACC_MAX - 1;

    typedef struct {
        logic signed [ANGLE_W-1:0] ang;
        logic signed [RATE_W-1:0]  rate;
        logic [DT_W-1:0]           dt;
        logic                      clr;
        logic                      known;
        logic signed [MOMENT_W-1:0] mom;
        logic                      sat;
    } stim_row_t;

    typedef struct {
        logic signed [MOMENT_W-1:0] mom;
        logic                       sat;
    } moment_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [ANGLE_W-1:0] angle_error = '0;
    logic signed [RATE_W-1:0] rate_measured = '0;
    logic [DT_W-1:0] step_ms = '0;
    logic clear_integral = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [MOMENT_W-1:0] moment;
    logic saturated;

    // predictor copy of the block's registers and state
    logic [GAIN_W-1:0] k_angle, k_p, k_i, k_d;
    logic [SHIFT_W-1:0] k_shift;
    longint prev_err, err_acc;

    moment_t moment_q[$];
    int errors = 0;
    bit calm = 0;

    cascaded_angle_rate_pid_axis u_top (.*);

    always #1 clk = ~clk;

    initial begin
        #20_000_000;
        $display("** cascaded_angle_rate_pid_axis: FAILED **");
        $finish;
    end

    function automatic longint absval(input longint x);
        return x < 0 ? -x : x;
    endfunction

    // min(floor(a*b/c), 2^61)
    function automatic longint scale_div(input longint a, input longint b, input longint c);
        logic [127:0] q;
        q = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
        return (q > 128'(TERM_LIM)) ? TERM_LIM : longint'(q[63:0]);
    endfunction

    function automatic moment_t pid_step(input logic signed [ANGLE_W-1:0] ang,
                                         input logic signed [RATE_W-1:0] rate,
                                         input logic [DT_W-1:0] dt, input logic clr);
        moment_t r;
        longint sp, e, diff, pt, dterm, iterm, total, m, nsum;
        r.mom = '0;
        r.sat = 1'b0;
        if (clr) begin
            err_acc = 0;
            return r;
        end
        m  = (longint'(k_angle) * absval(longint'(ang))) >>> GAIN_FRAC_DEF;
        sp = ang < 0 ? -m : m;
        e  = (sp - longint'(rate)) >>> k_shift;
        if (e > 64'sd2147483647) e = 64'sd2147483647;
        if (e < -64'sd2147483648) e = -64'sd2147483648;
        pt = longint'(k_p) * e;
        dterm = 0;
        if (dt != 0) begin
            diff  = e - prev_err;
            m     = scale_div(longint'(k_d) * absval(diff), 1000, longint'(dt));
            dterm = diff < 0 ? -m : m;
        end
        m     = scale_div(absval(err_acc), longint'(k_i), 1000);
        iterm = err_acc < 0 ? -m : m;
        total = pt + dterm + iterm;
        m = absval(total) >>> GAIN_FRAC_DEF;
        if (total < 0 && m > 64'sd2147483648) begin
            m = 64'sd2147483648;
            r.sat = 1'b1;
        end
        else if (total >= 0 && m > 64'sd2147483647) begin
            m = 64'sd2147483647;
            r.sat = 1'b1;
        end
        r.mom = MOMENT_W'(total < 0 ? -m : m);
        prev_err = e;
        nsum = err_acc + e * longint'(dt);
        if (nsum > ACC_MAX) begin
            nsum = ACC_MAX;
            r.sat = 1'b1;
        end
        if (nsum < ACC_MIN) begin
            nsum = ACC_MIN;
            r.sat = 1'b1;
        end
        err_acc = nsum;
        return r;
    endfunction

    task automatic report(input string what);
        errors++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    task automatic write_gains(input logic [GAIN_W-1:0] ga, gp, gi, gd,
                               input logic [SHIFT_W-1:0] sh);
        logic [CFG_DATA_W-1:0] v[5];
        logic [CFG_IDX_W-1:0] idx[5];
        v = '{ga, gp, gi, gd, CFG_DATA_W'(sh)};
        idx = '{REG_ANGLE_GAIN, REG_RATE_P_GAIN, REG_RATE_I_GAIN, REG_RATE_D_GAIN,
                REG_ERR_SHIFT};
        for (int n = 0; n < 5; n++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[n];
            cfg_data  <= v[n];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        k_angle = ga; k_p = gp; k_i = gi; k_d = gd; k_shift = sh;
    endtask

    task automatic drain();
        // the last transaction is already taken
        in_valid <= 1'b0;
        wait (moment_q.size() == 0);
        repeat (900) @(posedge clk);
    endtask

    task automatic send(input stim_row_t s);
        int g;
        moment_t r;
        g = calm ? 0 : $urandom_range(0, 17);
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid       <= 1'b1;
        angle_error    <= s.ang;
        rate_measured  <= s.rate;
        step_ms        <= s.dt;
        clear_integral <= s.clr;
        do @(posedge clk); while (in_stall);
        r = pid_step(s.ang, s.rate, s.dt, s.clr);
        if (s.known) begin
            r.mom = s.mom;
            r.sat = s.sat;
        end
        moment_q.push_back(r);
    endtask

    // result side
    initial begin
        int g;
        moment_t x;
        @(posedge rst_n);
        forever begin
            g = calm ? 0 : $urandom_range(0, 17);
            if (g > 0) begin
                out_stall <= 1'b1;
                repeat (g) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            if (moment_q.size() == 0)
                report($sformatf("unexpected transaction moment=%0d", moment));
            else begin
                x = moment_q.pop_front();
                if (moment !== x.mom)
                    report($sformatf("moment %0d, want %0d", moment, x.mom));
                if (saturated !== x.sat)
                    report($sformatf("saturated %b, want %b", saturated, x.sat));
            end
        end
    end

    initial begin
        stim_row_t rows[$];
        stim_row_t s;
        logic [GAIN_W-1:0] gmax;
        int bias;
        gmax = '1;
        k_angle = '0; k_p = '0; k_i = '0; k_d = '0; k_shift = '0;
        prev_err = 0;
        err_acc = 0;
        // ang, rate, dt, clr, known, moment, saturated
        rows = '{
            '{18'sh1FFFF, 21'sh100000, 15'h7FFF, 1'b0, 1'b1, 32'sd0, 1'b0},
            '{18'sh20000, 21'sh0FFFFF, 15'h0000, 1'b0, 1'b1, 32'sd0, 1'b0},
            '{18'sh00000, 21'sh000000, 15'h0001, 1'b0, 1'b1, 32'sd0, 1'b0},
            '{18'sh3FFFF, 21'sh1FFFFF, 15'h7FFF, 1'b1, 1'b1, 32'sd0, 1'b0},
            '{18'sh1FFFF, 21'sh0FFFFF, 15'h4000, 1'b0, 1'b1, 32'sd0, 1'b0},
            '{18'sh20000, 21'sh100000, 15'h7FFF, 1'b0, 1'b0, 32'sd0, 1'b0},
            '{18'sh1FFFF, 21'sh100000, 15'h0001, 1'b0, 1'b0, 32'sd0, 1'b0},
            '{18'sh20000, 21'sh0FFFFF, 15'h0001, 1'b0, 1'b0, 32'sd0, 1'b0},
            '{18'sh1FFFF, 21'sh100000, 15'h0000, 1'b0, 1'b0, 32'sd0, 1'b0},
            '{18'sh1FFFF, 21'sh100000, 15'h7FFF, 1'b0, 1'b0, 32'sd0, 1'b0},
            '{18'sh1FFFF, 21'sh100000, 15'h7FFF, 1'b0, 1'b0, 32'sd0, 1'b0},
            '{18'sh00000, 21'sh000000, 15'h7FFF, 1'b1, 1'b1, 32'sd0, 1'b0},
            '{18'sh00000, 21'sh000000, 15'h0000, 1'b0, 1'b0, 32'sd0, 1'b0},
            '{18'sh3FFFF, 21'sh000001, 15'h0002, 1'b0, 1'b0, 32'sd0, 1'b0},
            '{18'sh00001, 21'sh1FFFFF, 15'h03E8, 1'b0, 1'b0, 32'sd0, 1'b0},
            '{18'sh20000, 21'sh0FFFFF, 15'h7FFF, 1'b0, 1'b0, 32'sd0, 1'b0}
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // first rows run on the reset gains, where every moment is zero
        for (int n = 0; n < rows.size(); n++) begin
            if (n == 5) begin
                drain();
                write_gains(gmax, gmax, gmax, gmax, '0);
            end
            send(rows[n]);
        end

        for (int p = 0; p < PHASES; p++) begin
            drain();
            calm = (p == 3);
            case (p)
                0: write_gains(gmax, gmax, gmax, gmax, '0);
                1: write_gains(gmax, gmax, gmax, gmax, 4'hF);
                2: write_gains('0, '0, '0, '0, '0);
                3: write_gains(GAIN_W'($urandom_range(0, 1 << 16)),
                               GAIN_W'($urandom_range(0, 1 << 16)),
                               GAIN_W'($urandom_range(0, 1 << 16)),
                               GAIN_W'($urandom_range(0, 1 << 16)),
                               SHIFT_W'($urandom_range(0, 15)));
                default: write_gains(GAIN_W'($urandom), GAIN_W'($urandom),
                                     GAIN_W'($urandom), GAIN_W'($urandom),
                                     SHIFT_W'($urandom));
            endcase
            // long same-sign runs push the integrator into its limit
            bias = (p < 2) ? int'($urandom_range(0, 1)) : 2;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                s.ang   = ANGLE_W'($urandom);
                s.rate  = RATE_W'($urandom);
                s.known = 1'b0;
                s.clr   = ($urandom_range(0, 39) == 0);
                case ($urandom_range(0, 3))
                    0: s.dt = DT_W'($urandom_range(0, 3));
                    1: s.dt = DT_W'($urandom_range(1, 2000));
                    default: s.dt = DT_W'($urandom);
                endcase
                if (bias != 2 && $urandom_range(0, 1)) begin
                    s.clr = 1'b0;
                    s.ang[ANGLE_W-1] = bias[0];
                    s.rate[RATE_W-1] = ~bias[0];
                    s.dt = DT_W'($urandom_range(16000, 32767));
                end
                send(s);
            end
        end
        in_valid <= 1'b0;
        wait (moment_q.size() == 0);
        repeat (900) @(posedge clk);
        if (errors == 0)
            $display("** cascaded_angle_rate_pid_axis: PASSED **");
        else
            $display("** cascaded_angle_rate_pid_axis: FAILED **");
        $finish;
    end

endmodule

[cascaded_angle_rate_pid_axis.f]
sv/carp_pkg.sv
sv/carp_serial.sv
sv/cascaded_angle_rate_pid_axis.sv
sv/carp_checker.sv
tb/tb.sv
